// ===== rtl/dvi_pkg.sv =====
// shared constants and types for the disparity view interpolation row core
package dvi_pkg;

    localparam int PIX_W         = 8;
    localparam int DISP_W        = 8;
    localparam int VIEW_W        = 9;
    localparam int ALPHA_ONE     = 256;
    localparam int MAX_WIDTH_DEF = 2048;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register word index, taken from paddr[2]
    localparam logic REG_VIEW_POSITION = 1'b0;
    localparam logic [VIEW_W-1:0] VIEW_POSITION_RST = VIEW_W'(128);

    // request codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // one column of the stored input row
    typedef struct packed {
        logic                     we;
        logic [PIX_W-1:0]         left;
        logic [PIX_W-1:0]         right;
        logic signed [DISP_W-1:0] disp;
    } dvi_row_wr_t;

    // one write into the output row
    typedef struct packed {
        logic             we;
        logic [PIX_W-1:0] data;
    } dvi_pix_wr_t;

    // warp sequencer handshake
    typedef struct packed {
        logic start;
    } dvi_warp_ctl_t;

    typedef struct packed {
        logic busy;
    } dvi_warp_sts_t;

endpackage

// ===== rtl/dvi_if.sv =====
// stream interfaces for the pixel input and the interpolated output
interface dvi_in_if import dvi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [PIX_W-1:0]         left_pixel;
    logic [PIX_W-1:0]         right_pixel;
    logic signed [DISP_W-1:0] disparity;
    logic                     row_end;

    modport source (
        output valid, req_type, left_pixel, right_pixel, disparity, row_end,
        input  ready
    );
    modport sink (
        input  valid, req_type, left_pixel, right_pixel, disparity, row_end,
        output ready
    );
endinterface

interface dvi_out_if import dvi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             out_row_end;

    modport source (
        output valid, out_pixel, out_row_end,
        input  ready
    );
    modport sink (
        input  valid, out_pixel, out_row_end,
        output ready
    );
endinterface

// ===== rtl/dvi_warp.sv =====
// row memories and the pipelined forward-warp walk over one stored row
module dvi_warp import dvi_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dvi_row_wr_t                  row_wr,
    input  logic [$clog2(MAX_WIDTH)-1:0] row_waddr,
    input  dvi_warp_ctl_t                ctl,
    input  logic [$clog2(MAX_WIDTH):0]   row_len,
    input  logic [VIEW_W-1:0]            alpha,
    output dvi_warp_sts_t                sts,
    output dvi_pix_wr_t                  out_wr,
    output logic [$clog2(MAX_WIDTH)-1:0] out_waddr
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int LW     = AW + 1;
    // source column spans the row plus a full disparity either way
    localparam int SW     = ((AW > DISP_W) ? AW : DISP_W) + 2;
    // target numerator spans 256 * column plus a full weighted disparity
    localparam int NW     = ((AW > 8) ? AW : 8) + 10;
    localparam int AD_W   = VIEW_W + 1 + DISP_W;
    localparam int PROD_W = VIEW_W + PIX_W;

    logic [PIX_W-1:0]         left_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]         right_mem [MAX_WIDTH];
    logic [DISP_W-1:0]        disp_mem  [MAX_WIDTH];

    logic                     run_reg;
    logic [AW-1:0]            x1_reg;
    logic [LW-1:0]            len_reg;

    logic [PIX_W-1:0]         left_q;
    logic [DISP_W-1:0]        disp_q;
    logic [PIX_W-1:0]         right_q;

    logic                     v1_reg;
    logic [AW-1:0]            x1_s1_reg;

    logic                     v2_reg;
    logic [AW-1:0]            x1_s2_reg;
    logic [PIX_W-1:0]         left_s2_reg;
    logic signed [AD_W-1:0]   ad_s2_reg;
    logic                     x2ok_s2_reg;

    logic                     v3_reg;
    logic                     ok3_reg;
    logic [AW-1:0]            xi3_reg;
    logic [PROD_W-1:0]        pl3_reg;
    logic [PROD_W-1:0]        pr3_reg;

    logic signed [DISP_W-1:0] d_s1;
    logic signed [SW-1:0]     x2_s1;
    logic                     x2ok_s1;
    logic [AW-1:0]            x2_addr;
    logic signed [AD_W-1:0]   ad_next;
    logic                     last_x1;

    logic signed [NW-1:0]     n_s2;
    logic                     xiok_s2;
    logic [AW-1:0]            xi_s2;
    logic [VIEW_W-1:0]        inv_alpha;
    logic [PROD_W-1:0]        pl_next;
    logic [PROD_W-1:0]        pr_next;
    logic [PROD_W:0]          sum_s3;

    // row storage: written by pixel transfers, read by the warp walk
    always_ff @(posedge clk)
    begin
        if (row_wr.we)
        begin
            left_mem[row_waddr]  <= row_wr.left;
            right_mem[row_waddr] <= row_wr.right;
            disp_mem[row_waddr]  <= row_wr.disp;
        end
        left_q  <= left_mem[x1_reg];
        disp_q  <= disp_mem[x1_reg];
        right_q <= right_mem[x2_addr];
    end

    assign last_x1 = (LW'(x1_reg) + LW'(1)) == len_reg;

    // stage 1: source column and weight times disparity
    always_comb
    begin
        d_s1    = $signed(disp_q);
        x2_s1   = $signed(SW'(x1_s1_reg)) - SW'(d_s1);
        x2ok_s1 = !x2_s1[SW-1] && (x2_s1 < $signed(SW'(len_reg)));
        x2_addr = x2_s1[AW-1:0];
        ad_next = $signed({1'b0, alpha}) * d_s1;
    end

    // stage 2: target column and the two weighted pixels
    always_comb
    begin
        n_s2 = $signed(NW'({x1_s2_reg, 8'b0})) - NW'(ad_s2_reg);
        if (n_s2[NW-1])
        begin
            // only a magnitude below one column truncates to column zero
            xiok_s2 = (&n_s2[NW-1:8]) && (n_s2[7:0] != 8'd0);
            xi_s2   = '0;
        end
        else
        begin
            xiok_s2 = n_s2[NW-1:8] < (NW-8)'(len_reg);
            xi_s2   = n_s2[AW+7:8];
        end
        inv_alpha = VIEW_W'(ALPHA_ONE) - alpha;
        pl_next   = PROD_W'(inv_alpha) * PROD_W'(left_s2_reg);
        pr_next   = PROD_W'(alpha) * PROD_W'(right_q);
    end

    // stage 3: blend and write out
    assign sum_s3      = {1'b0, pl3_reg} + {1'b0, pr3_reg};
    assign out_wr.we   = v3_reg && ok3_reg;
    assign out_wr.data = sum_s3[PIX_W+7:8];
    assign out_waddr   = xi3_reg;
    assign sts.busy    = run_reg || v1_reg || v2_reg || v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            x1_reg      <= '0;
            len_reg     <= '0;
            v1_reg      <= 1'b0;
            x1_s1_reg   <= '0;
            v2_reg      <= 1'b0;
            x1_s2_reg   <= '0;
            left_s2_reg <= '0;
            ad_s2_reg   <= '0;
            x2ok_s2_reg <= 1'b0;
            v3_reg      <= 1'b0;
            ok3_reg     <= 1'b0;
            xi3_reg     <= '0;
            pl3_reg     <= '0;
            pr3_reg     <= '0;
        end
        else
        begin
            if (ctl.start)
            begin
                run_reg <= 1'b1;
                x1_reg  <= '0;
                len_reg <= row_len;
            end
            else if (run_reg)
            begin
                if (last_x1)
                begin
                    run_reg <= 1'b0;
                end
                x1_reg <= x1_reg + AW'(1);
            end

            v1_reg    <= run_reg && !ctl.start;
            x1_s1_reg <= x1_reg;

            v2_reg      <= v1_reg;
            x1_s2_reg   <= x1_s1_reg;
            left_s2_reg <= left_q;
            ad_s2_reg   <= ad_next;
            x2ok_s2_reg <= x2ok_s1;

            v3_reg  <= v2_reg;
            ok3_reg <= x2ok_s2_reg && xiok_s2;
            xi3_reg <= xi_s2;
            pl3_reg <= pl_next;
            pr3_reg <= pr_next;
        end
    end

endmodule

// ===== rtl/disparity_view_interpolation_row_core.sv =====
// top level: pixel stream, output row memory, row-end clear and warp sequencing
// result path: each transfer's result passes through the pending stage into the output register
// throughput: one transfer per cycle inside a row while the pending stage or output register
//   can move on; at a row end input stalls for the clear of stale output entries (previous
//   row length minus this one, if positive) plus the warp walk over the stored row
// reset: output row reads as zero until the first row end, which sweeps every entry past it
module disparity_view_interpolation_row_core import dvi_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dvi_in_if.sink                pix_in,
    dvi_out_if.source             pix_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_WARP
    } state_t;

    state_t             state_reg;

    // column position and row bookkeeping
    logic [AW-1:0]      col_reg;
    logic [LW-1:0]      row_len_reg;
    logic [LW-1:0]      dirty_reg;      // output entries at or above this are known zero
    logic               zero_row_reg;   // output memory not yet cleared since reset
    logic               warp_pend_reg;
    logic [LW-1:0]      clr_reg;
    logic [VIEW_W-1:0]  view_reg;

    // result waiting on the output memory read
    logic               pend_reg;
    logic               pend_end_reg;
    logic               pend_zero_reg;
    logic [PIX_W-1:0]   rdata_reg;

    // output register
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_pixel_reg;
    logic               out_end_reg;

    logic [PIX_W-1:0]   out_mem [MAX_WIDTH];

    logic               accept;
    logic               pend_move;
    logic               row_last;
    logic               clr_active;
    logic               cfg_wr;
    logic [VIEW_W-1:0]  alpha;

    logic               om_we;
    logic [AW-1:0]      om_addr;
    logic [PIX_W-1:0]   om_data;

    dvi_row_wr_t        row_wr;
    dvi_warp_ctl_t      warp_ctl;
    dvi_warp_sts_t      warp_sts;
    dvi_pix_wr_t        warp_wr;
    logic [AW-1:0]      warp_waddr;

    // pending result moves on once the output register is free or being taken
    assign pend_move    = pend_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = (state_reg == S_IDLE) && (!pend_reg || !out_valid_reg || pix_out.ready);
    assign accept       = pix_in.valid && pix_in.ready;

    // a row also ends internally at the last column the memories hold
    assign row_last   = pix_in.row_end || (col_reg == AW'(MAX_WIDTH - 1));
    assign clr_active = (state_reg == S_CLEAR) && (clr_reg < dirty_reg);

    assign pix_out.valid       = out_valid_reg;
    assign pix_out.out_pixel   = out_pixel_reg;
    assign pix_out.out_row_end = out_end_reg;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VIEW_POSITION) ? APB_DATA_W'(view_reg) : '0;
    assign alpha  = (view_reg > VIEW_W'(ALPHA_ONE)) ? VIEW_W'(ALPHA_ONE) : view_reg;

    // stored row columns for the warp
    assign row_wr.we    = accept && (pix_in.req_type == REQ_PIXEL);
    assign row_wr.left  = pix_in.left_pixel;
    assign row_wr.right = pix_in.right_pixel;
    assign row_wr.disp  = pix_in.disparity;

    // warp starts in the cycle the clear sweep finishes
    assign warp_ctl.start = (state_reg == S_CLEAR) && !clr_active && warp_pend_reg;

    // output memory write port: read-and-clear by transfers, clear sweep, warp results
    always_comb
    begin
        priority if (accept)
        begin
            om_we   = 1'b1;
            om_addr = col_reg;
            om_data = '0;
        end
        else if (clr_active)
        begin
            om_we   = 1'b1;
            om_addr = clr_reg[AW-1:0];
            om_data = '0;
        end
        else
        begin
            om_we   = warp_wr.we;
            om_addr = warp_waddr;
            om_data = warp_wr.data;
        end
    end

    // each transfer reads its column and zeroes it, so a row leaves behind only the
    // entries beyond the next row's length; the clear sweep covers those
    always_ff @(posedge clk)
    begin
        if (om_we)
        begin
            out_mem[om_addr] <= om_data;
        end
        if (accept)
        begin
            rdata_reg <= out_mem[col_reg];
        end
    end

    dvi_warp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_warp (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_wr    (row_wr),
        .row_waddr (col_reg),
        .ctl       (warp_ctl),
        .row_len   (row_len_reg),
        .alpha     (alpha),
        .sts       (warp_sts),
        .out_wr    (warp_wr),
        .out_waddr (warp_waddr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_len_reg   <= '0;
            dirty_reg     <= LW'(MAX_WIDTH);
            zero_row_reg  <= 1'b1;
            warp_pend_reg <= 1'b0;
            clr_reg       <= '0;
            view_reg      <= VIEW_POSITION_RST;
            pend_reg      <= 1'b0;
            pend_end_reg  <= 1'b0;
            pend_zero_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_VIEW_POSITION))
            begin
                view_reg <= pwdata[VIEW_W-1:0];
            end

            // output register
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
                out_pixel_reg <= pend_zero_reg ? '0 : rdata_reg;
                out_end_reg   <= pend_end_reg;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // pending stage
            if (accept)
            begin
                pend_reg      <= 1'b1;
                pend_end_reg  <= pix_in.row_end;
                pend_zero_reg <= zero_row_reg;
            end
            else if (pend_move)
            begin
                pend_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (row_last)
                        begin
                            col_reg       <= '0;
                            clr_reg       <= LW'(col_reg) + LW'(1);
                            warp_pend_reg <= (pix_in.req_type == REQ_PIXEL);
                            state_reg     <= S_CLEAR;
                            if (pix_in.req_type == REQ_PIXEL)
                            begin
                                row_len_reg <= LW'(col_reg) + LW'(1);
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + AW'(1);
                        end
                    end
                end
                S_CLEAR:
                begin
                    if (clr_active)
                    begin
                        clr_reg <= clr_reg + LW'(1);
                    end
                    else
                    begin
                        // whole output row now zero
                        dirty_reg    <= '0;
                        zero_row_reg <= 1'b0;
                        state_reg    <= warp_pend_reg ? S_WARP : S_IDLE;
                    end
                end
                S_WARP:
                begin
                    if (!warp_sts.busy)
                    begin
                        // warp writes only targets below the row length
                        dirty_reg     <= row_len_reg;
                        warp_pend_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
